@@ src/drmc_pkg.sv @@
// Package: mode codes, lamp and actuator bit positions, command codes, constants.
package drmc_pkg;

	typedef enum logic [3:0] {
		M_OFF       = 4'd0,
		M_MAN_VEL   = 4'd1,
		M_AUTO_IDLE = 4'd2,
		M_DRILL     = 4'd3,
		M_UPDOWN    = 4'd4,
		M_CUR_TEST  = 4'd5,
		M_AUTO_HOLD = 4'd6,
		M_AUTO_FREE = 4'd7,
		M_HOME      = 4'd8,
		M_HOME_FREE = 4'd9,
		M_APPROACH  = 4'd10,
		M_MAN_TORQ  = 4'd11,
		M_MAN_HOLD  = 4'd12,
		M_MAN_FREE  = 4'd13,
		M_RSVD14    = 4'd14,
		M_RSVD15    = 4'd15
	} mode_t;

	localparam int LP_READY = 0, LP_INVALID = 1, LP_AUTO = 2, LP_MANUAL = 3;
	localparam int LP_DRAW = 4, LP_DRILL = 5, LP_PUMP = 6;
	localparam int AC_DRILL = 0, AC_VEL = 1, AC_TORQUE = 2, AC_UP = 3, AC_DOWN = 4;
	localparam int AC_PUMP = 5;

	localparam logic [1:0] FU_START = 2'd0, FU_STOP = 2'd1, FU_AUTO = 2'd2, FU_MANUAL = 2'd3;
	localparam logic SV_CURRENT = 1'b0, SV_VELOCITY = 1'b1;

	localparam logic [15:0] STEP_AUTO = 16'd25;
	localparam logic [15:0] STEP_MANUAL = 16'd50;
	localparam logic [15:0] LONG_WAIT = 16'd40;
	localparam logic [15:0] SHORT_WAIT = 16'd20;
	localparam logic [15:0] UP_PHASE_END = 16'd16;
	localparam logic [15:0] DOWN_PHASE_START = 16'd24;
	localparam logic [15:0] TEST_CURRENT = 16'd700;

	localparam logic [2:0] R_HOME = 3'd0, R_MTORQ = 3'd1, R_HOLD = 3'd2, R_FLOOR = 3'd3;
	localparam logic [2:0] R_CEIL = 3'd4, R_FREQ = 3'd5, R_VEL = 3'd6, R_DEPTH = 3'd7;

	typedef struct packed {
		logic [15:0] home_current;
		logic [15:0] manual_torque_current;
		logic [15:0] hold_current;
		logic [15:0] current_floor;
		logic [15:0] current_ceiling;
		logic [15:0] drill_frequency;
		logic [15:0] approach_velocity;
		logic signed [15:0] approach_depth;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [15:0] wait_count;
		logic [15:0] current;
		logic        changed;
		logic        fu_pending;
		logic        servo_pending;
		logic [6:0]  lamps;
		logic [5:0]  acts;
	} ctl_state_t;

	typedef struct packed {
		logic [6:0]  lamps;
		logic [5:0]  acts;
		logic        fu_valid;
		logic [1:0]  fu_cmd;
		logic [15:0] fu_arg;
		logic        sv_valid;
		logic        sv_cmd;
		logic [15:0] sv_arg;
		logic        zero;
		logic [3:0]  mode;
	} result_t;

endpackage

@@ src/drmc_step.sv @@
// Combinational next-state and result logic for one controller tick.
module drmc_step (
	input  drmc_pkg::cfg_t       cfg,
	input  drmc_pkg::ctl_state_t cur,
	input  logic [11:0]          switches,
	input  logic                 fu_ack,
	input  logic                 servo_ack,
	input  logic signed [15:0]   block_position,
	output drmc_pkg::ctl_state_t nxt,
	output drmc_pkg::result_t    res
);
	import drmc_pkg::*;

	logic estop, manual, autom, ack, drill, up, down, pump, temp_ok;
	logic up_free, down_free, auto_free, auto_lost;
	logic [3:0]  md;
	logic [15:0] wc, cs, step;
	logic        chg, fp, sp, man;
	logic [6:0]  lp;
	logic [5:0]  ac;
	logic        fv, sv, zs, past;
	logic [1:0]  fc;
	logic        sc;
	logic [15:0] fa, sa;

	assign estop = switches[0];
	assign manual = switches[1];
	assign autom = switches[2];
	assign ack = switches[3];
	assign drill = switches[4];
	assign up = switches[5];
	assign down = switches[6];
	assign pump = switches[7];
	assign temp_ok = switches[8];
	assign up_free = switches[9];
	assign down_free = switches[10];
	assign auto_free = switches[11];
	assign auto_lost = !autom || estop;

	always_comb begin
		md = cur.mode;
		wc = cur.wait_count;
		cs = cur.current;
		chg = cur.changed;
		fp = cur.fu_pending && !fu_ack;
		sp = cur.servo_pending && !servo_ack;
		lp = cur.lamps;
		ac = cur.acts;
		fv = 1'b0; sv = 1'b0; zs = 1'b0;
		fc = FU_START; sc = SV_CURRENT; fa = '0; sa = '0;
		past = 1'b0;
		man = (cur.mode == M_MAN_TORQ);
		step = man ? STEP_MANUAL : STEP_AUTO;
		case (cur.mode)
			M_OFF: begin
				lp = lp & 7'h03;
				ac = '0;
				lp[LP_INVALID] = estop;
				lp[LP_READY] = !estop;
				if (manual && !estop && !fp) begin
					fv = 1'b1; fc = FU_MANUAL; fp = 1'b1; md = M_MAN_VEL;
				end
				if (autom && !estop && !fp) begin
					fv = 1'b1; fc = FU_AUTO; fp = 1'b1; md = M_AUTO_IDLE;
				end
			end
			M_MAN_VEL: begin
				lp[LP_AUTO] = 1'b0; lp[LP_MANUAL] = 1'b1;
				ac[AC_TORQUE] = 1'b0; ac[AC_VEL] = 1'b1;
				if (drill) begin
					if (ac[AC_DRILL]) lp[LP_INVALID] = !temp_ok;
					lp[LP_DRILL] = 1'b1; ac[AC_DRILL] = 1'b1;
				end else begin
					lp[LP_DRILL] = 1'b0; ac[AC_DRILL] = 1'b0;
				end
				if (up) begin
					if (ac[AC_UP]) lp[LP_INVALID] = !up_free;
					lp[LP_DRAW] = 1'b1; ac[AC_UP] = 1'b1; ac[AC_DOWN] = 1'b0;
				end else if (down) begin
					if (ac[AC_DOWN]) lp[LP_INVALID] = !down_free;
					lp[LP_DRAW] = 1'b1; ac[AC_DOWN] = 1'b1; ac[AC_UP] = 1'b0;
				end else begin
					lp[LP_DRAW] = 1'b0; ac[AC_DOWN] = 1'b0; ac[AC_UP] = 1'b0;
					lp[LP_INVALID] = 1'b0;
				end
				lp[LP_PUMP] = pump; ac[AC_PUMP] = pump;
				if (!manual || estop) md = M_OFF;
				if (ack && !sp) begin
					sv = 1'b1; sc = SV_VELOCITY; sa = cfg.approach_velocity; sp = 1'b1;
					cs = cfg.manual_torque_current; wc = '0;
					ac[AC_VEL] = 1'b0; ac[AC_TORQUE] = 1'b1;
					chg = 1'b0; md = M_MAN_TORQ;
				end
			end
			M_AUTO_IDLE: begin
				lp[LP_MANUAL] = 1'b0; lp[LP_DRAW] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0;
				ac = '0; ac[AC_VEL] = 1'b1;
				lp[LP_AUTO] = !lp[LP_AUTO];
				if (auto_lost && !fp) begin
					fv = 1'b1; fc = FU_MANUAL; fp = 1'b1; md = M_OFF;
				end
				if (ack && !sp) begin
					sv = 1'b1; sc = SV_VELOCITY; sa = cfg.approach_velocity; sp = 1'b1;
					cs = cfg.home_current; wc = '0;
					ac[AC_VEL] = 1'b0; ac[AC_TORQUE] = 1'b1;
					md = M_HOME;
				end
			end
			M_DRILL: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b1;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0; lp[LP_DRAW] = 1'b0;
				ac = '0; ac[AC_VEL] = 1'b1;
				past = wc > LONG_WAIT;
				wc = wc + 16'd1;
				if (past && !fp) begin
					fv = 1'b1; fc = FU_STOP; fp = 1'b1; wc = '0; md = M_UPDOWN;
				end
				if (auto_lost && !fp) begin
					fv = 1'b1; fc = FU_STOP; fp = 1'b1; md = M_AUTO_IDLE;
				end
			end
			M_UPDOWN: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0;
				ac[AC_DRILL] = 1'b0; ac[AC_VEL] = 1'b1; ac[AC_TORQUE] = 1'b0;
				ac[AC_PUMP] = 1'b0;
				if (wc < UP_PHASE_END) begin
					ac[AC_UP] = 1'b1; ac[AC_DOWN] = 1'b0; lp[LP_DRAW] = 1'b1;
				end else if (wc > DOWN_PHASE_START) begin
					ac[AC_UP] = 1'b0; ac[AC_DOWN] = 1'b1; lp[LP_DRAW] = 1'b1;
				end else begin
					ac[AC_UP] = 1'b0; ac[AC_DOWN] = 1'b0; lp[LP_DRAW] = 1'b0;
				end
				past = wc > LONG_WAIT;
				wc = wc + 16'd1;
				if (past && !sp) begin
					sv = 1'b1; sc = SV_VELOCITY; sa = cfg.approach_velocity; sp = 1'b1;
					cs = TEST_CURRENT;
					ac[AC_VEL] = 1'b0; ac[AC_TORQUE] = 1'b1;
					md = M_CUR_TEST;
				end
				if (auto_lost) md = M_AUTO_IDLE;
			end
			M_CUR_TEST, M_MAN_TORQ: begin
				if (man) begin
					lp[LP_AUTO] = 1'b0; lp[LP_MANUAL] = 1'b1;
					ac[AC_TORQUE] = 1'b1; ac[AC_VEL] = 1'b0;
					if (drill) begin
						if (ac[AC_DRILL]) lp[LP_INVALID] = !temp_ok;
						lp[LP_DRILL] = 1'b1; ac[AC_DRILL] = 1'b1;
					end else begin
						lp[LP_DRILL] = 1'b0; ac[AC_DRILL] = 1'b0;
					end
				end else begin
					lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
					lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0;
					ac = '0; ac[AC_TORQUE] = 1'b1;
				end
				lp[LP_DRAW] = !lp[LP_DRAW];
				if (down) begin
					if (man) chg = 1'b1;
					if (cs > cfg.current_floor) cs = cs - step;
					if (!sp) begin
						sv = 1'b1; sc = SV_CURRENT; sa = cs; sp = 1'b1;
					end
				end
				if (up) begin
					if (man) chg = 1'b1;
					if (cs < cfg.current_ceiling) cs = cs + step;
					if (!sp) begin
						sv = 1'b1; sc = SV_CURRENT; sa = cs; sp = 1'b1;
					end
				end
				if (man) begin
					lp[LP_PUMP] = pump; ac[AC_PUMP] = pump;
				end
				if (ack && (!man || chg) && !sp) begin
					sv = 1'b1; sc = SV_CURRENT; sa = cfg.hold_current; sp = 1'b1;
					wc = '0; md = man ? M_MAN_HOLD : M_AUTO_HOLD;
				end
				if ((man ? (!manual || estop) : auto_lost) && !sp) begin
					sv = 1'b1; sc = SV_CURRENT; sa = cfg.hold_current; sp = 1'b1;
					wc = '0; md = man ? M_MAN_HOLD : M_AUTO_HOLD;
				end
				if (!auto_free) begin
					ac[AC_VEL] = 1'b1; ac[AC_TORQUE] = 1'b0;
					md = man ? M_MAN_FREE : M_AUTO_FREE;
				end
			end
			M_AUTO_HOLD: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0; lp[LP_DRAW] = 1'b0;
				ac = '0; ac[AC_TORQUE] = 1'b1;
				if (!sp) begin
					sv = 1'b1; sc = SV_CURRENT; sa = cfg.hold_current; sp = 1'b1;
				end
				past = wc > SHORT_WAIT;
				wc = wc + 16'd1;
				if (past) md = M_AUTO_IDLE;
			end
			M_AUTO_FREE, M_HOME_FREE: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0; lp[LP_DRAW] = 1'b0;
				ac = '0; ac[AC_VEL] = 1'b1; ac[AC_UP] = 1'b1; ac[AC_DOWN] = 1'b1;
				if (up_free && down_free) begin
					if (cur.mode == M_AUTO_FREE) md = M_AUTO_IDLE;
					else begin
						md = M_APPROACH; zs = 1'b1;
					end
				end
			end
			M_HOME: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0;
				ac = '0; ac[AC_TORQUE] = 1'b1;
				lp[LP_DRAW] = !lp[LP_DRAW];
				if (!sp && wc == '0) begin
					wc = 16'd1;
					sv = 1'b1; sc = SV_CURRENT; sa = cs; sp = 1'b1;
				end
				if (auto_lost && !sp) begin
					sv = 1'b1; sc = SV_CURRENT; sa = cfg.hold_current; sp = 1'b1;
					wc = '0; md = M_AUTO_HOLD;
				end
				if (!auto_free) begin
					ac[AC_VEL] = 1'b1; ac[AC_TORQUE] = 1'b0; md = M_HOME_FREE;
				end
			end
			M_APPROACH: begin
				lp[LP_AUTO] = 1'b1; lp[LP_MANUAL] = 1'b0; lp[LP_DRILL] = 1'b0;
				lp[LP_PUMP] = 1'b0; lp[LP_INVALID] = 1'b0; lp[LP_DRAW] = 1'b1;
				ac = '0; ac[AC_VEL] = 1'b1; ac[AC_DOWN] = 1'b1;
				if (block_position < cfg.approach_depth) begin
					ac[AC_DOWN] = 1'b0; lp[LP_DRAW] = 1'b0;
					if (!fp) begin
						fv = 1'b1; fc = FU_START; fa = cfg.drill_frequency; fp = 1'b1;
						wc = '0; md = M_DRILL;
					end
				end
				if (auto_lost) md = M_AUTO_IDLE;
			end
			M_MAN_HOLD: begin
				lp[LP_DRAW] = 1'b0;
				ac[AC_VEL] = 1'b0; ac[AC_TORQUE] = 1'b1;
				ac[AC_UP] = 1'b0; ac[AC_DOWN] = 1'b0;
				if (!sp) begin
					sv = 1'b1; sc = SV_CURRENT; sa = cfg.hold_current; sp = 1'b1;
				end
				past = wc > SHORT_WAIT;
				wc = wc + 16'd1;
				if (past) md = M_MAN_VEL;
			end
			M_MAN_FREE: begin
				lp[LP_DRAW] = 1'b1;
				ac[AC_VEL] = 1'b1; ac[AC_TORQUE] = 1'b0;
				ac[AC_UP] = 1'b1; ac[AC_DOWN] = 1'b1;
				if (up_free && down_free) md = M_MAN_VEL;
			end
			default: begin
			end
		endcase

		nxt.mode = md;
		nxt.wait_count = wc;
		nxt.current = cs;
		nxt.changed = chg;
		nxt.fu_pending = fp;
		nxt.servo_pending = sp;
		nxt.lamps = lp;
		nxt.acts = ac;

		res.lamps = lp;
		res.acts = ac;
		res.fu_valid = fv;
		res.fu_cmd = fc;
		res.fu_arg = fa;
		res.sv_valid = sv;
		res.sv_cmd = sc;
		res.sv_arg = sa;
		res.zero = zs;
		res.mode = md;
	end

endmodule

@@ src/drill_rig_mode_controller_core.sv @@
// Top level: drill rig mode controller with stream ports and register write port.
// Each tick transaction updates the controller state on acceptance, and its result
// lands in an output register, so a tick is accepted every cycle while the result
// side takes results (or the output register is empty). The rate is set by the
// state update loop through the mode logic.
module drill_rig_mode_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // switches[11:0], fu_ack[12], servo_ack[13], block_position[29:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // lamps, actuators, fu_cmd_valid, fu_command, fu_argument,
	                              // servo_cmd_valid, servo_command, servo_argument,
	                              // position_zero, mode (lowest first, 55 bits, top bit zero)
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import drmc_pkg::*;

	cfg_t       cfg_q;
	ctl_state_t st_q, st_nxt;
	result_t    res, res_q;
	logic       valid_q, accept;

	assign s_tready = !valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	drmc_step u_step (
		.cfg            (cfg_q),
		.cur            (st_q),
		.switches       (s_tdata[11:0]),
		.fu_ack         (s_tdata[12]),
		.servo_ack      (s_tdata[13]),
		.block_position (s_tdata[29:14]),
		.nxt            (st_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.home_current <= 16'd12000;
			cfg_q.manual_torque_current <= 16'd950;
			cfg_q.hold_current <= 16'd1000;
			cfg_q.current_floor <= 16'd100;
			cfg_q.current_ceiling <= 16'd3000;
			cfg_q.drill_frequency <= 16'd2828;
			cfg_q.approach_velocity <= 16'd600;
			cfg_q.approach_depth <= -16'sd125;
		end else if (cfg_we) begin
			case (cfg_index)
				R_HOME:  cfg_q.home_current <= cfg_data;
				R_MTORQ: cfg_q.manual_torque_current <= cfg_data;
				R_HOLD:  cfg_q.hold_current <= cfg_data;
				R_FLOOR: cfg_q.current_floor <= cfg_data;
				R_CEIL:  cfg_q.current_ceiling <= cfg_data;
				R_FREQ:  cfg_q.drill_frequency <= cfg_data;
				R_VEL:   cfg_q.approach_velocity <= cfg_data;
				R_DEPTH: cfg_q.approach_depth <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: M_OFF, wait_count: 16'd0, current: 16'd0, changed: 1'b0,
				fu_pending: 1'b0, servo_pending: 1'b0, lamps: 7'h01, acts: 6'd0};
			valid_q <= 1'b0;
		end else begin
			if (accept) st_q <= st_nxt;
			if (accept) valid_q <= 1'b1;
			else if (m_tready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) res_q <= res;
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {1'b0, res_q.mode, res_q.zero, res_q.sv_arg, res_q.sv_cmd,
		res_q.sv_valid, res_q.fu_arg, res_q.fu_cmd, res_q.fu_valid, res_q.acts,
		res_q.lamps};

`ifndef SYNTHESIS
	a_pend_fu: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.fu_valid |=> st_q.fu_pending)
		else $error("drive pending not set after command");
	a_pend_sv: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.sv_valid |=> st_q.servo_pending)
		else $error("servo pending not set after command");
	a_mode_out: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_q.mode == st_q.mode)
		else $error("result mode differs from state");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("stalled result changed");
`endif

endmodule
